FILE: sv/bps_pkg.sv
// ----------------------------------------------------------------------------
// bps_pkg
// Types, widths and constants shared by the stroke smoother modules.
// ----------------------------------------------------------------------------
package bps_pkg;

  // Coordinate word: signed fixed point, 20 bits.
  localparam int CW = 20;
  // Control point sums such as 7*p0 + 6*p1 - p2 need four more bits.
  localparam int EW = 24;
  // One weighted term: a control value times a weight of at most 768.
  localparam int PW = 30;
  // Sum of the four weighted terms.
  localparam int NW = 32;
  // Rounded magnitude divided by four, ready for the divide by 375.
  localparam int VW = 29;
  // Reciprocal of 375, scaled by two to the RECIP_SHIFT.
  localparam int RW = 30;
  localparam int RECIP_SHIFT = 38;
  localparam logic [RW-1:0] RECIP = 30'd733007752;
  // Quotient width after the reciprocal multiply.
  localparam int QW = VW + RW - RECIP_SHIFT;
  // Half of the divisor 1500, added before truncation.
  localparam int ROUND_BIAS = 750;
  localparam int WW = 10;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [EW-1:0] ctrl_t;
  typedef logic [3:0][WW-1:0] wset_t;

  localparam coord_t COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(CW-1){1'b0}}};

  // Cubic segment in the scaled form c0, e1/12, e2/12, c3.
  typedef struct packed {
    coord_t c0;
    ctrl_t  e1;
    ctrl_t  e2;
    coord_t c3;
  } seg_t;

  // One output step as it travels down the pipeline.
  typedef struct packed {
    logic       valid;
    logic       direct;
    logic [2:0] m;
    logic       last;
  } step_t;

  function automatic ctrl_t widen(input coord_t v);
    return {{(EW-CW){v[CW-1]}}, v};
  endfunction

  // Weights of c0, e1, e2 and c3 at t = m/5: 12a^3, 3a^2m, 3am^2, 12m^3 with a = 5 - m.
  // Element 0 weighs c0.
  function automatic wset_t weights(input logic [2:0] m);
    wset_t w;
    case (m)
      3'd1:    w = {10'd12, 10'd12, 10'd48, 10'd768};
      3'd2:    w = {10'd96, 10'd36, 10'd54, 10'd324};
      3'd3:    w = {10'd324, 10'd54, 10'd36, 10'd96};
      3'd4:    w = {10'd768, 10'd48, 10'd12, 10'd12};
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

FILE: sv/bps_sequencer.sv
// ----------------------------------------------------------------------------
// bps_sequencer
// Holds the point window, takes input items and steps through the output
// points of each item, one step descriptor per cycle while adv is high.
// ----------------------------------------------------------------------------
module bps_sequencer (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            in_valid,
  output logic            in_ready,
  input  bps_pkg::coord_t in_x,
  input  bps_pkg::coord_t in_y,
  input  logic            in_last,
  output bps_pkg::step_t  step,
  output bps_pkg::seg_t   seg_x,
  output bps_pkg::seg_t   seg_y
);

  typedef enum logic [1:0] {KIND_ONE, KIND_TWO, KIND_SEG, KIND_END} kind_t;
  typedef enum logic [1:0] {PICK_P0, PICK_P1, PICK_P2} pick_t;

  // The second segment of a final window starts at this step.
  localparam logic [3:0] IDX_MID = 4'd5;
  localparam logic [3:0] IDX_END = 4'd10;

  logic [1:0]      held;
  logic [1:0]      held_next;
  bps_pkg::coord_t older_x, older_y, newer_x, newer_y;
  bps_pkg::coord_t jp0_x, jp0_y, jp1_x, jp1_y, jp2_x, jp2_y;
  logic            job_active;
  kind_t           job_kind;
  logic [3:0]      job_idx;
  logic [3:0]      job_end;
  logic            accept;
  logic            new_job;
  kind_t           new_kind;
  logic [3:0]      new_end;
  logic            emit;
  logic            d_direct;
  logic            d_second;
  logic            d_last;
  logic [2:0]      d_m;
  logic [3:0]      idx_b;
  pick_t           d_pick;

  function automatic bps_pkg::seg_t build_seg(
    input bps_pkg::coord_t p0,
    input bps_pkg::coord_t p1,
    input bps_pkg::coord_t p2,
    input logic            second,
    input logic            direct,
    input pick_t           pick
  );
    bps_pkg::ctrl_t w0, w1, w2, six1;
    bps_pkg::seg_t  s;
    w0 = bps_pkg::widen(p0);
    w1 = bps_pkg::widen(p1);
    w2 = bps_pkg::widen(p2);
    six1 = (w1 <<< 2) + (w1 <<< 1);
    if (!second) begin
      s.c0 = p0;
      s.e1 = (w0 <<< 3) - w0 + six1 - w2;
      s.e2 = (w0 + six1 - w2) <<< 1;
      s.c3 = p1;
    end else begin
      s.c0 = p1;
      s.e1 = (six1 - w0 + w2) <<< 1;
      s.e2 = six1 - w0 + (w2 <<< 3) - w2;
      s.c3 = p2;
    end
    // A point that is passed through travels in c0.
    if (direct) begin
      case (pick)
        PICK_P0: s.c0 = p0;
        PICK_P1: s.c0 = p1;
        default: s.c0 = p2;
      endcase
    end
    return s;
  endfunction

  assign in_ready = !job_active || (adv && (job_idx == job_end));
  assign accept   = in_valid && in_ready;
  assign emit     = adv && job_active;

  always_comb begin
    new_job   = 1'b0;
    new_kind  = KIND_ONE;
    held_next = 2'd0;
    case (held)
      2'd0: begin
        new_job   = in_last;
        held_next = in_last ? 2'd0 : 2'd1;
      end
      2'd1: begin
        new_job   = in_last;
        new_kind  = KIND_TWO;
        held_next = in_last ? 2'd0 : 2'd2;
      end
      default: begin
        new_job   = 1'b1;
        new_kind  = in_last ? KIND_END : KIND_SEG;
        held_next = in_last ? 2'd0 : 2'd2;
      end
    endcase
    case (new_kind)
      KIND_ONE: new_end = 4'd0;
      KIND_TWO: new_end = 4'd1;
      KIND_SEG: new_end = IDX_MID - 4'd1;
      default:  new_end = IDX_END;
    endcase
  end

  // Step descriptor for the current position within the job.
  always_comb begin
    d_direct = 1'b1;
    d_second = 1'b0;
    d_last   = 1'b0;
    d_m      = '0;
    d_pick   = PICK_P2;
    idx_b    = job_idx - IDX_MID;
    case (job_kind)
      KIND_ONE: d_last = 1'b1;
      KIND_TWO: begin
        if (job_idx == 4'd0) begin
          d_pick = PICK_P1;
        end else begin
          d_last = 1'b1;
        end
      end
      default: begin
        if (job_idx == 4'd0) begin
          d_pick = PICK_P0;
        end else if (job_idx < IDX_MID) begin
          d_direct = 1'b0;
          d_m      = job_idx[2:0];
        end else if (job_idx == IDX_MID) begin
          d_pick = PICK_P1;
        end else if (job_idx < IDX_END) begin
          d_direct = 1'b0;
          d_second = 1'b1;
          d_m      = idx_b[2:0];
        end else begin
          d_last = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held       <= 2'd0;
      job_active <= 1'b0;
      job_kind   <= KIND_ONE;
      job_idx    <= '0;
      job_end    <= '0;
      step       <= '0;
    end else begin
      if (adv) begin
        if (job_active) begin
          step.valid  <= 1'b1;
          step.direct <= d_direct;
          step.m      <= d_m;
          step.last   <= d_last;
        end else begin
          step.valid <= 1'b0;
        end
      end
      // A new job starts only when no job is active or when the current one issues its last step.
      if (accept && new_job) begin
        job_active <= 1'b1;
        job_kind   <= new_kind;
        job_idx    <= '0;
        job_end    <= new_end;
      end else if (emit) begin
        job_idx <= job_idx + 4'd1;
        if (job_idx == job_end) begin
          job_active <= 1'b0;
        end
      end
      if (accept) begin
        held <= held_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (!in_last) begin
        older_x <= newer_x;
        older_y <= newer_y;
        newer_x <= in_x;
        newer_y <= in_y;
      end
      if (new_job) begin
        jp0_x <= older_x;
        jp0_y <= older_y;
        jp1_x <= newer_x;
        jp1_y <= newer_y;
        jp2_x <= in_x;
        jp2_y <= in_y;
      end
    end
    if (emit) begin
      seg_x <= build_seg(jp0_x, jp1_x, jp2_x, d_second, d_direct, d_pick);
      seg_y <= build_seg(jp0_y, jp1_y, jp2_y, d_second, d_direct, d_pick);
    end
  end

endmodule

FILE: sv/bps_curve_eval.sv
// ----------------------------------------------------------------------------
// bps_curve_eval
// Three-stage evaluation of one coordinate of a cubic point: weighted terms,
// rounded magnitude, reciprocal divide by 1500. The final sign and
// saturation are combinational after the last stage.
// ----------------------------------------------------------------------------
module bps_curve_eval (
  input  logic            clk,
  input  logic            en,
  input  bps_pkg::step_t  step,
  input  bps_pkg::seg_t   seg,
  output bps_pkg::coord_t res
);

  bps_pkg::wset_t                w;
  logic signed [bps_pkg::EW+bps_pkg::WW:0] t0, t1, t2, t3;
  logic signed [bps_pkg::PW-1:0] p0, p1, p2, p3;
  bps_pkg::coord_t               c0_1, c0_2, c0_3;
  logic                          dir1, dir2, dir3;
  logic signed [bps_pkg::NW-1:0] n;
  logic [bps_pkg::NW-1:0]        mag;
  logic [bps_pkg::NW-1:0]        madd;
  logic [bps_pkg::VW-1:0]        v2;
  logic                          neg2, neg3;
  logic [bps_pkg::VW+bps_pkg::RW-1:0] prod;
  logic [bps_pkg::QW-1:0]        q3;
  logic signed [bps_pkg::QW:0]   sq;
  logic                          ovf;
  bps_pkg::coord_t               sat;

  always_comb begin
    w  = bps_pkg::weights(step.m);
    t0 = $signed({1'b0, w[0]}) * seg.c0;
    t1 = $signed({1'b0, w[1]}) * seg.e1;
    t2 = $signed({1'b0, w[2]}) * seg.e2;
    t3 = $signed({1'b0, w[3]}) * seg.c3;
  end

  always_comb begin
    n    = bps_pkg::NW'(p0) + bps_pkg::NW'(p1) + bps_pkg::NW'(p2) + bps_pkg::NW'(p3);
    mag  = n[bps_pkg::NW-1] ? -n : n;
    madd = mag + bps_pkg::NW'(bps_pkg::ROUND_BIAS);
  end

  assign prod = v2 * bps_pkg::RECIP;

  // Ties round away from zero: the magnitude is rounded, then the sign goes back on.
  always_comb begin
    sq  = neg3 ? -$signed({1'b0, q3}) : $signed({1'b0, q3});
    ovf = !((&sq[bps_pkg::QW:bps_pkg::CW-1]) || !(|sq[bps_pkg::QW:bps_pkg::CW-1]));
    if (ovf) begin
      sat = sq[bps_pkg::QW] ? bps_pkg::COORD_MIN : bps_pkg::COORD_MAX;
    end else begin
      sat = sq[bps_pkg::CW-1:0];
    end
    res = dir3 ? c0_3 : sat;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0   <= t0[bps_pkg::PW-1:0];
      p1   <= t1[bps_pkg::PW-1:0];
      p2   <= t2[bps_pkg::PW-1:0];
      p3   <= t3[bps_pkg::PW-1:0];
      c0_1 <= seg.c0;
      dir1 <= step.direct;
      v2   <= madd[bps_pkg::VW+1:2];
      neg2 <= n[bps_pkg::NW-1];
      c0_2 <= c0_1;
      dir2 <= dir1;
      q3   <= prod[bps_pkg::VW+bps_pkg::RW-1:bps_pkg::RECIP_SHIFT];
      neg3 <= neg2;
      c0_3 <= c0_2;
      dir3 <= dir2;
    end
  end

endmodule

FILE: sv/bezier_polyline_smoother.sv
// ----------------------------------------------------------------------------
// bezier_polyline_smoother
// Streams a stroke through cubic Bezier subdivision, one output point per cycle unless stalled.
// ----------------------------------------------------------------------------
// Each accepted point produces its output points at one per cycle while the
// output is not stalled: none for the first two points of a stroke, five for
// each later point, eleven for a final point after two held points, and one
// or two for strokes of one or two points. A new item is taken in the cycle
// its predecessor issues its last point, or at once when no item is in
// progress. The first point of an item passes through the job registers, the
// step register, three arithmetic stages and the output register. A stall
// on the output holds the whole pipeline.
module bezier_polyline_smoother (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  bps_pkg::coord_t in_x,
  input  bps_pkg::coord_t in_y,
  input  logic            in_last,
  output logic            out_valid,
  input  logic            out_ready,
  output bps_pkg::coord_t out_x,
  output bps_pkg::coord_t out_y,
  output logic            out_last
);

  logic            adv;
  bps_pkg::step_t  step;
  bps_pkg::seg_t   seg_x;
  bps_pkg::seg_t   seg_y;
  bps_pkg::coord_t res_x;
  bps_pkg::coord_t res_y;
  logic [2:0]      vld;
  logic [2:0]      lst;

  assign adv = !out_valid || out_ready;

  bps_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_x     (in_x),
    .in_y     (in_y),
    .in_last  (in_last),
    .step     (step),
    .seg_x    (seg_x),
    .seg_y    (seg_y)
  );

  bps_curve_eval u_eval_x (
    .clk  (clk),
    .en   (adv),
    .step (step),
    .seg  (seg_x),
    .res  (res_x)
  );

  bps_curve_eval u_eval_y (
    .clk  (clk),
    .en   (adv),
    .step (step),
    .seg  (seg_y),
    .res  (res_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[1:0], step.valid};
      out_valid <= vld[2];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lst      <= {lst[1:0], step.last};
      out_last <= lst[2];
      out_x    <= res_x;
      out_y    <= res_y;
    end
  end

endmodule

FILE: sv/bps_checker.sv
// ----------------------------------------------------------------------------
// bps_checker
// Port-level checks on the stroke smoother, bound to the top level.
// ----------------------------------------------------------------------------
module bps_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input bps_pkg::coord_t out_x,
  input bps_pkg::coord_t out_y,
  input logic            out_last
);

  // Reset empties the pipeline and leaves the input side open.
  assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

  // A stalled result item holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
      && $stable(out_last))
    else $error("stalled result item changed");

  // While an item is in progress, the input side cannot open during an output stall.
  assert property (@(posedge clk) disable iff (rst)
    !in_ready && out_valid && !out_ready |=> !in_ready || out_ready)
    else $error("input opened while output stalled");

endmodule

bind bezier_polyline_smoother bps_checker u_bps_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_x     (out_x),
  .out_y     (out_y),
  .out_last  (out_last)
);
